/* rtl/core/jfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfc_pkg
// Shared types, constants and the byte-wide CRC-32 update for the journal
// frame checker.
// ----------------------------------------------------------------------------
package jfc_pkg;

	localparam int OFFSET_BITS_DEF = 48;
	localparam int HEADER_BYTES    = 16;

	localparam logic [31:0] FRAME_MAGIC      = 32'h4A46_564F;
	localparam logic [31:0] CRC_POLY         = 32'hEDB8_8320;
	localparam logic [31:0] ALL_ONES         = 32'hFFFF_FFFF;
	localparam logic [31:0] VERSION_WORD     = 32'h0000_0001;
	localparam logic [31:0] MAX_RECORD_RESET = 32'd4096;

	// register index as decoded from paddr[2]
	localparam logic REG_MAX_RECORD = 1'b0;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [2:0] {
		KIND_PAYLOAD   = 3'd0,
		KIND_GOOD      = 3'd1,
		KIND_HDR_BAD   = 3'd2,
		KIND_CRC_BAD   = 3'd3,
		KIND_TRUNC_HDR = 3'd4,
		KIND_TRUNC_PAY = 3'd5,
		KIND_CLEAN_END = 3'd6
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [31:0] frame_length;
		logic        last;
	} res_t;

	// results produced by one item; both share the same frame offset
	typedef struct packed {
		logic [1:0] num;
		res_t       r0;
		res_t       r1;
	} push_t;

	function automatic res_t mk_res(kind_t k, logic [7:0] pb, logic [31:0] len, logic lst);
		res_t r;
		r.kind         = k;
		r.payload_byte = pb;
		r.frame_length = len;
		r.last         = lst;
		return r;
	endfunction

	// reflected CRC-32, one byte
	function automatic logic [31:0] crc_byte(logic [31:0] crc_in, logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'h0, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

endpackage

/* rtl/core/journal_frame_checker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// journal_frame_checker_core
// Checks a stream of length-prefixed journal frames carrying a CRC-32.
//
// Input channel (in_valid/in_ready): one beat per stream byte (mode 0) or an
// end-of-stream marker (mode 1). Output channel (out_valid/out_ready): one
// beat per result: forwarded payload byte, frame verdict, header error,
// truncation or clean end, with the frame length and start offset.
// The limit max_record_bytes sits at APB address 0 (reset 4096); write it
// only while the block is idle.
// Path: an accepted beat is registered, then decoded and written into the result queue.
// Throughput: one input byte per cycle; the last payload byte of a frame
// makes two output beats, so the one-beat-per-cycle output port sets the
// rate there. An eight-entry result queue decouples the two sides and
// in_ready drops when it cannot take the results of two more beats.
// Reset clears all frame state and the queue; after a header error, a CRC
// mismatch or an end-of-stream marker the block drops further input until
// the next reset. A stalled receiver just fills the queue, then backs
// pressure onto in_ready.
// ----------------------------------------------------------------------------
module journal_frame_checker_core #(
	parameter int OFFSET_BITS = jfc_pkg::OFFSET_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   mode,
	input  logic [7:0]             data_byte,

	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [2:0]             kind,
	output logic [7:0]             payload_byte,
	output logic [31:0]            frame_length,
	output logic [OFFSET_BITS-1:0] frame_start_offset,
	output logic                   last,

	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import jfc_pkg::*;

	logic        valid_s1;
	logic        mode_s1;
	logic [7:0]  byte_s1;
	logic [31:0] max_q;
	logic        room;
	push_t       push;
	res_t        out_res;
	logic [OFFSET_BITS-1:0] push_offset;

	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_MAX_RECORD) ? max_q : 32'h0;
	assign in_ready = room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_RECORD_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_MAX_RECORD) begin
			max_q <= pwdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode;
			byte_s1 <= data_byte;
		end
	end

	jfc_parser #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid_s1        (valid_s1),
		.mode_s1         (mode_s1),
		.byte_s1         (byte_s1),
		.max_record_bytes(max_q),
		.push            (push),
		.push_offset     (push_offset)
	);

	jfc_out_fifo #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_offset(push_offset),
		.pend       (valid_s1),
		.room       (room),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_res    (out_res),
		.out_offset (frame_start_offset)
	);

	assign kind         = out_res.kind;
	assign payload_byte = out_res.payload_byte;
	assign frame_length = out_res.frame_length;
	assign last         = out_res.last;

endmodule

/* rtl/core/jfc_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfc_parser
// Frame state and per-beat decode: header checks, payload forwarding, CRC
// and end-of-frame / end-of-stream verdicts. Produces up to two results.
// ----------------------------------------------------------------------------
module jfc_parser #(
	parameter int OFFSET_BITS = jfc_pkg::OFFSET_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid_s1,
	input  logic                   mode_s1,
	input  logic [7:0]             byte_s1,
	input  logic [31:0]            max_record_bytes,
	output jfc_pkg::push_t         push,
	output logic [OFFSET_BITS-1:0] push_offset
);
	import jfc_pkg::*;

	typedef enum logic {
		PH_HEADER  = 1'b0,
		PH_PAYLOAD = 1'b1
	} phase_t;

	localparam logic [3:0] POS_MAGIC   = 4'd3;
	localparam logic [3:0] POS_VERSION = 4'd7;
	localparam logic [3:0] POS_LENGTH  = 4'd11;
	localparam logic [3:0] POS_LAST    = 4'(HEADER_BYTES - 1);

	phase_t                 phase_q, phase_n;
	logic [3:0]             hcnt_q, hcnt_n;
	logic [31:0]            shift_q, shift_n;
	logic [31:0]            len_q, len_n;
	logic [31:0]            stored_q, stored_n;
	logic [31:0]            crc_q, crc_n;
	logic [31:0]            rem_q, rem_n;
	logic [OFFSET_BITS-1:0] off_q, off_n;
	logic [OFFSET_BITS-1:0] fstart_q, fstart_n;
	logic                   hbad_q, hbad_n;
	logic                   halted_q, halted_n;

	always_comb begin
		phase_n     = phase_q;
		hcnt_n      = hcnt_q;
		shift_n     = shift_q;
		len_n       = len_q;
		stored_n    = stored_q;
		crc_n       = crc_q;
		rem_n       = rem_q;
		off_n       = off_q;
		fstart_n    = fstart_q;
		hbad_n      = hbad_q;
		halted_n    = halted_q;
		push        = '0;
		push_offset = fstart_q;

		if (valid_s1 && !halted_q) begin
			if (mode_s1) begin
				halted_n = 1'b1;
				push.num = 2'd1;
				if (phase_q == PH_PAYLOAD) begin
					push.r0 = mk_res(KIND_TRUNC_PAY, 8'h00, len_q, 1'b1);
				end else if (hcnt_q == 4'd0) begin
					push.r0     = mk_res(KIND_CLEAN_END, 8'h00, 32'h0, 1'b1);
					push_offset = off_q;
				end else begin
					push.r0 = mk_res(KIND_TRUNC_HDR, 8'h00, 32'h0, 1'b1);
				end
			end else if (phase_q == PH_PAYLOAD) begin
				off_n = off_q + OFFSET_BITS'(1);
				crc_n = crc_byte(crc_q, byte_s1);
				rem_n = rem_q - 32'd1;
				if (rem_n != 32'd0) begin
					push.num = 2'd1;
					push.r0  = mk_res(KIND_PAYLOAD, byte_s1, len_q, 1'b1);
				end else begin
					push.num = 2'd2;
					push.r0  = mk_res(KIND_PAYLOAD, byte_s1, len_q, 1'b0);
					if (~crc_n == stored_q) begin
						push.r1 = mk_res(KIND_GOOD, 8'h00, len_q, 1'b1);
					end else begin
						push.r1  = mk_res(KIND_CRC_BAD, 8'h00, len_q, 1'b1);
						halted_n = 1'b1;
					end
					phase_n = PH_HEADER;
					hcnt_n  = 4'd0;
				end
			end else begin
				if (hcnt_q == 4'd0) begin
					fstart_n = off_q;
					hbad_n   = 1'b0;
				end
				off_n   = off_q + OFFSET_BITS'(1);
				shift_n = {byte_s1, shift_q[31:8]};
				if (hcnt_q == POS_MAGIC && shift_n != FRAME_MAGIC)
					hbad_n = 1'b1;
				if (hcnt_q == POS_VERSION && shift_n != VERSION_WORD)
					hbad_n = 1'b1;
				if (hcnt_q == POS_LENGTH)
					len_n = shift_n;
				push_offset = fstart_n;
				if (hcnt_q != POS_LAST) begin
					hcnt_n = hcnt_q + 4'd1;
				end else begin
					stored_n = shift_n;
					hcnt_n   = 4'd0;
					if (hbad_n || len_n > max_record_bytes) begin
						halted_n = 1'b1;
						push.num = 2'd1;
						push.r0  = mk_res(KIND_HDR_BAD, 8'h00, len_n, 1'b1);
					end else begin
						crc_n = ALL_ONES;
						if (len_n == 32'd0) begin
							push.num = 2'd1;
							// empty payload: finished CRC is zero
							if (shift_n == 32'd0) begin
								push.r0 = mk_res(KIND_GOOD, 8'h00, 32'h0, 1'b1);
							end else begin
								push.r0  = mk_res(KIND_CRC_BAD, 8'h00, 32'h0, 1'b1);
								halted_n = 1'b1;
							end
						end else begin
							rem_n   = len_n;
							phase_n = PH_PAYLOAD;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			hcnt_q   <= 4'd0;
			shift_q  <= 32'h0;
			len_q    <= 32'h0;
			stored_q <= 32'h0;
			crc_q    <= ALL_ONES;
			rem_q    <= 32'h0;
			off_q    <= '0;
			fstart_q <= '0;
			hbad_q   <= 1'b0;
			halted_q <= 1'b0;
		end else begin
			phase_q  <= phase_n;
			hcnt_q   <= hcnt_n;
			shift_q  <= shift_n;
			len_q    <= len_n;
			stored_q <= stored_n;
			crc_q    <= crc_n;
			rem_q    <= rem_n;
			off_q    <= off_n;
			fstart_q <= fstart_n;
			hbad_q   <= hbad_n;
			halted_q <= halted_n;
		end
	end

endmodule

/* rtl/core/jfc_out_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfc_out_fifo
// Result queue: takes up to two results a cycle, hands out one beat a cycle while out_ready is high.
// Flags room when the item in flight and one more fit.
// ----------------------------------------------------------------------------
module jfc_out_fifo #(
	parameter int OFFSET_BITS = jfc_pkg::OFFSET_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  jfc_pkg::push_t         push,
	input  logic [OFFSET_BITS-1:0] push_offset,
	input  logic                   pend,
	output logic                   room,
	output logic                   out_valid,
	input  logic                   out_ready,
	output jfc_pkg::res_t          out_res,
	output logic [OFFSET_BITS-1:0] out_offset
);
	import jfc_pkg::*;

	res_t                   res_mem [FIFO_DEPTH];
	logic [OFFSET_BITS-1:0] off_mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]     wp_q, rp_q;
	logic [FIFO_CW-1:0]     count_q;
	logic [FIFO_AW-1:0]     wp_nx;
	logic                   pop;
	logic [FIFO_CW:0]       load;

	assign wp_nx      = wp_q + FIFO_AW'(1);
	assign out_valid  = (count_q != '0);
	assign pop        = out_valid && out_ready;
	assign out_res    = res_mem[rp_q];
	assign out_offset = off_mem[rp_q];
	assign load       = {1'b0, count_q} + (pend ? (FIFO_CW+1)'(2) : '0);
	assign room       = (load <= (FIFO_CW+1)'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			res_mem[wp_q] <= push.r0;
			off_mem[wp_q] <= push_offset;
		end
		if (push.num == 2'd2) begin
			res_mem[wp_nx] <= push.r1;
			off_mem[wp_nx] <= push_offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + FIFO_AW'(push.num);
			if (pop)
				rp_q <= rp_q + FIFO_AW'(1);
			count_q <= count_q + FIFO_CW'(push.num) - FIFO_CW'(pop);
		end
	end

endmodule

/* tb/sv/journal_frame_checker_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// journal_frame_checker_core_tb
// Self-checking bench for the journal frame checker. A queue of stream beats
// (headers, payloads, end marker) feeds a valid/ready driver. An in-bench
// frame tracker predicts every result beat, and the monitor compares each
// output beat field by field. The limit register is moved through several
// settings over APB between drained phases. The stream ends with one
// randomly chosen closing event, followed by beats the halted block drops.
// ----------------------------------------------------------------------------
module journal_frame_checker_core_tb;
	import jfc_pkg::*;

	localparam int OFS_W = OFFSET_BITS_DEF;

	typedef struct {
		logic       mode;
		logic [7:0] b;
		bit         hold;
	} stream_beat_t;

	typedef struct {
		kind_t            kind;
		logic [7:0]       pbyte;
		logic [31:0]      flen;
		logic [OFS_W-1:0] fstart;
		logic             last;
	} result_beat_t;

	typedef enum int {
		END_CLEAN, END_TRUNC_HDR, END_TRUNC_PAY, END_CRC_PAY, END_CRC_EMPTY,
		END_BAD_MAGIC, END_BAD_VERSION, END_TOO_LONG, END_NOISE
	} stream_end_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             mode = 1'b0;
	logic [7:0]       data_byte = 8'h00;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [2:0]       kind;
	logic [7:0]       payload_byte;
	logic [31:0]      frame_length;
	logic [OFS_W-1:0] frame_start_offset;
	logic             last;
	logic             psel = 1'b0;
	logic             penable = 1'b0;
	logic             pwrite = 1'b0;
	logic [2:0]       paddr = 3'd0;
	logic [31:0]      pwdata = 32'd0;
	logic [31:0]      prdata;
	logic             pready;

	journal_frame_checker_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready), .kind(kind),
		.payload_byte(payload_byte), .frame_length(frame_length),
		.frame_start_offset(frame_start_offset), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	localparam logic [2:0] LIMIT_ADDR  = {REG_MAX_RECORD, 2'b00};
	localparam logic [2:0] UNUSED_ADDR = {~REG_MAX_RECORD, 2'b00};

	stream_beat_t beat_queue[$];
	result_beat_t due_results[$];
	stream_beat_t next_beat;
	result_beat_t want;

	// frame tracker state
	logic             trk_in_payload = 1'b0;
	logic [3:0]       trk_hdr_count = 4'd0;
	logic [31:0]      trk_shift = 32'd0;
	logic [31:0]      trk_len = 32'd0;
	logic [31:0]      trk_crc_stored = 32'd0;
	logic [31:0]      trk_crc = ALL_ONES;
	logic [31:0]      trk_left = 32'd0;
	logic [31:0]      trk_limit = MAX_RECORD_RESET;
	logic [OFS_W-1:0] trk_offset = '0;
	logic [OFS_W-1:0] trk_fstart = '0;
	logic             trk_hdr_bad = 1'b0;
	logic             trk_halted = 1'b0;

	bit          quiet = 1'b0;
	int          in_gap = 0;
	int          out_stall = 0;
	logic        in_beat_taken = 1'b0;
	logic        out_beat_taken = 1'b0;
	int          err_count = 0;
	int          beats_taken = 0;
	int          results_checked = 0;
	int          frames_good = 0;
	int          limit_settings = 0;
	stream_end_t ending;

	function automatic logic [31:0] crc32_next(logic [31:0] c, logic [7:0] d);
		logic [31:0] r;
		r = c;
		for (int k = 0; k < 8; k++)
			r = (r[0] ^ d[k]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	function automatic void expect_result(kind_t k, logic [7:0] pb, logic [31:0] len,
			logic [OFS_W-1:0] st, logic lst);
		result_beat_t r;
		r.kind = k;
		r.pbyte = pb;
		r.flen = len;
		r.fstart = st;
		r.last = lst;
		due_results = {due_results, r};
	endfunction

	function automatic kind_t frame_verdict();
		if (~trk_crc == trk_crc_stored)
			return KIND_GOOD;
		trk_halted = 1'b1;
		return KIND_CRC_BAD;
	endfunction

	function automatic void track_stream_beat(logic m, logic [7:0] b);
		logic [3:0] pos;
		if (trk_halted)
			return;
		if (m) begin
			trk_halted = 1'b1;
			if (trk_in_payload)
				expect_result(KIND_TRUNC_PAY, 8'h00, trk_len, trk_fstart, 1'b1);
			else if (trk_hdr_count == 4'd0)
				expect_result(KIND_CLEAN_END, 8'h00, 32'd0, trk_offset, 1'b1);
			else
				expect_result(KIND_TRUNC_HDR, 8'h00, 32'd0, trk_fstart, 1'b1);
			return;
		end
		if (trk_in_payload) begin
			trk_offset = trk_offset + OFS_W'(1);
			trk_crc = crc32_next(trk_crc, b);
			trk_left = trk_left - 32'd1;
			expect_result(KIND_PAYLOAD, b, trk_len, trk_fstart, trk_left != 32'd0);
			if (trk_left == 32'd0) begin
				expect_result(frame_verdict(), 8'h00, trk_len, trk_fstart, 1'b1);
				trk_in_payload = 1'b0;
				trk_hdr_count = 4'd0;
			end
			return;
		end
		pos = trk_hdr_count;
		if (pos == 4'd0) begin
			trk_fstart = trk_offset;
			trk_hdr_bad = 1'b0;
		end
		trk_offset = trk_offset + OFS_W'(1);
		trk_shift = {b, trk_shift[31:8]};
		if (pos == 4'd3 && trk_shift != FRAME_MAGIC)
			trk_hdr_bad = 1'b1;
		if (pos == 4'd7 && trk_shift != VERSION_WORD)
			trk_hdr_bad = 1'b1;
		if (pos == 4'd11)
			trk_len = trk_shift;
		if (pos != 4'(HEADER_BYTES - 1)) begin
			trk_hdr_count = pos + 4'd1;
			return;
		end
		trk_crc_stored = trk_shift;
		trk_hdr_count = 4'd0;
		if (trk_hdr_bad || trk_len > trk_limit) begin
			trk_halted = 1'b1;
			expect_result(KIND_HDR_BAD, 8'h00, trk_len, trk_fstart, 1'b1);
			return;
		end
		trk_crc = ALL_ONES;
		if (trk_len == 32'd0) begin
			expect_result(frame_verdict(), 8'h00, 32'd0, trk_fstart, 1'b1);
			return;
		end
		trk_left = trk_len;
		trk_in_payload = 1'b1;
	endfunction

	function automatic void push_beat(logic m, logic [7:0] b, bit h);
		stream_beat_t s;
		s.mode = m;
		s.b = b;
		s.hold = h;
		beat_queue = {beat_queue, s};
	endfunction

	function automatic void queue_header(logic [31:0] magic, logic [31:0] ver,
			logic [31:0] len, logic [31:0] crc, int upto, bit h);
		logic [127:0] hdr;
		hdr = {crc, len, ver, magic};
		for (int i = 0; i < upto; i++)
			push_beat(1'b0, hdr[8*i +: 8], h && i == 0);
	endfunction

	function automatic void queue_frame(int len, logic [31:0] crc_err, bit h);
		logic [7:0]  body[$];
		logic [31:0] c;
		c = ALL_ONES;
		for (int i = 0; i < len; i++) begin
			body = {body, 8'($urandom)};
			c = crc32_next(c, body[i]);
		end
		queue_header(FRAME_MAGIC, VERSION_WORD, len, ~c ^ crc_err, HEADER_BYTES, h);
		foreach (body[i])
			push_beat(1'b0, body[i], 1'b0);
	endfunction

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr[2] == REG_MAX_RECORD) begin
			trk_limit = val;
			limit_settings++;
		end
	endtask

	task automatic limit_check(input logic [31:0] want_val);
		logic [31:0] got;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= LIMIT_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== want_val) begin
			$error("max_record_bytes: expected %0d, got %0d", want_val, got);
			err_count++;
		end
	endtask

	task automatic wait_drained();
		while (beat_queue.size() != 0 || in_valid || due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// input side: acceptance and prediction
	always @(posedge clk) begin
		in_beat_taken <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			track_stream_beat(mode, data_byte);
			beats_taken++;
		end
	end

	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_beat_taken)) begin
			if (in_gap != 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (beat_queue.size() != 0
					&& !(beat_queue[0].hold && due_results.size() != 0)) begin
				next_beat = beat_queue.pop_front();
				in_valid <= 1'b1;
				mode <= next_beat.mode;
				data_byte <= next_beat.b;
				in_gap <= quiet ? 0 : $urandom_range(0, 5);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side: backpressure and checking
	always @(negedge clk) begin
		if (out_beat_taken)
			out_stall = quiet ? 0 : $urandom_range(0, 5);
		if (out_stall != 0) begin
			out_ready <= 1'b0;
			out_stall--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		out_beat_taken <= arst_n && out_valid && out_ready;
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				$error("unexpected result beat, kind %0d", kind);
				err_count++;
			end else begin
				want = due_results.pop_front();
				results_checked++;
				if (want.kind == KIND_GOOD)
					frames_good++;
				if (kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, kind);
					err_count++;
				end
				if (payload_byte !== want.pbyte) begin
					$error("payload_byte: expected %0h, got %0h", want.pbyte, payload_byte);
					err_count++;
				end
				if (frame_length !== want.flen) begin
					$error("frame_length: expected %0d, got %0d", want.flen, frame_length);
					err_count++;
				end
				if (frame_start_offset !== want.fstart) begin
					$error("frame_start_offset: expected %0d, got %0d", want.fstart,
						frame_start_offset);
					err_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					err_count++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("journal_frame_checker_core test failed");
		$finish;
	end

	initial begin
		logic [31:0] limits[6];
		logic [31:0] len32;
		int          budget;
		int          cap;
		int          len;
		int          nb;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		limit_check(MAX_RECORD_RESET);

		// empty frame, then a two-byte frame that waits for the first verdict
		queue_header(FRAME_MAGIC, VERSION_WORD, 32'd0, 32'd0, HEADER_BYTES, 1'b0);
		queue_header(FRAME_MAGIC, VERSION_WORD, 32'd2,
			~crc32_next(crc32_next(ALL_ONES, 8'h00), 8'hFF), HEADER_BYTES, 1'b1);
		push_beat(1'b0, 8'h00, 1'b0);
		push_beat(1'b0, 8'hFF, 1'b0);
		wait_drained();

		limits = '{ALL_ONES, 32'd0, 32'd40, 32'd1, $urandom | 32'h0000_1000,
			MAX_RECORD_RESET};
		foreach (limits[p]) begin
			reg_write(UNUSED_ADDR, $urandom);
			reg_write(LIMIT_ADDR, limits[p]);
			limit_check(limits[p]);
			quiet = (p == 2);
			budget = 0;
			while (budget < 64) begin
				cap = (limits[p] < 48) ? int'(limits[p]) : 48;
				case ($urandom_range(0, 7))
					0: len = 0;
					1: len = cap;
					default: len = $urandom_range(0, cap);
				endcase
				queue_frame(len, 32'd0, $urandom_range(0, 9) == 0);
				budget += HEADER_BYTES + len;
			end
			wait_drained();
		end
		quiet = 1'b0;

		ending = stream_end_t'($urandom_range(0, int'(END_NOISE)));
		reg_write(LIMIT_ADDR, (ending == END_TRUNC_PAY) ? ALL_ONES : MAX_RECORD_RESET);
		limit_check(trk_limit);
		case (ending)
			END_CLEAN: ;
			END_TRUNC_HDR: queue_header(FRAME_MAGIC, VERSION_WORD, 32'd5, 32'd0,
				$urandom_range(1, HEADER_BYTES - 1), 1'b0);
			END_TRUNC_PAY: begin
				nb = $urandom_range(0, 20);
				len32 = $urandom_range(0, 1) ? ALL_ONES : nb + 1 + $urandom_range(0, 40);
				queue_header(FRAME_MAGIC, VERSION_WORD, len32, $urandom, HEADER_BYTES, 1'b0);
				repeat (nb) push_beat(1'b0, 8'($urandom), 1'b0);
			end
			END_CRC_PAY: queue_frame($urandom_range(1, 40), 32'd1 << $urandom_range(0, 31),
				1'b0);
			END_CRC_EMPTY: queue_header(FRAME_MAGIC, VERSION_WORD, 32'd0, $urandom | 32'd1,
				HEADER_BYTES, 1'b0);
			END_BAD_MAGIC: queue_header(FRAME_MAGIC ^ (32'd1 << $urandom_range(0, 31)),
				VERSION_WORD, 32'd8, 32'd0, HEADER_BYTES, 1'b0);
			END_BAD_VERSION: queue_header(FRAME_MAGIC,
				VERSION_WORD ^ (32'd1 << $urandom_range(0, 31)), 32'd8, 32'd0,
				HEADER_BYTES, 1'b0);
			END_TOO_LONG: queue_header(FRAME_MAGIC, VERSION_WORD,
				$urandom_range(0, 1) ? MAX_RECORD_RESET + 1 : ALL_ONES, 32'd0,
				HEADER_BYTES, 1'b0);
			default: repeat (HEADER_BYTES) push_beat(1'b0, 8'($urandom), 1'b0);
		endcase
		push_beat(1'b1, 8'($urandom), 1'b0);
		// halted from here on: these are dropped
		repeat (6) push_beat($urandom_range(0, 1), 8'($urandom), 1'b0);
		wait_drained();
		repeat (10) @(posedge clk);

		$display("%0d stream beats taken, %0d result beats checked, %0d frames good",
			beats_taken, results_checked, frames_good);
		$display("%0d limit settings; stream closed by %s", limit_settings, ending.name());
		if (err_count == 0)
			$display("journal_frame_checker_core test passed");
		else
			$display("journal_frame_checker_core test failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/jfc_pkg.sv
rtl/core/jfc_parser.sv
rtl/core/jfc_out_fifo.sv
rtl/core/journal_frame_checker_core.sv
tb/sv/journal_frame_checker_core_tb.sv
